FILE: rtl/bmhq_pkg.sv
// Package with the types, constants and compare function of the binary min-heap queue.
package bmhq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Output tdata: popped_key, popped_valid, entry_total, top_key, top_valid.
	localparam int OUT_BITS    = KEY_W + 1 + CNT_W + KEY_W + 1;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_POP_RD,
		ST_POP_LD,
		ST_DN_RD,
		ST_DN_CMP,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t             command;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [KEY_W-1:0] popped_key;
		logic             popped_valid;
		logic [CNT_W-1:0] entry_total;
		logic [KEY_W-1:0] top_key;
		logic             top_valid;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} mem_req_t;

	// Strictly-less compare; signed order flips the sign bits.
	function automatic logic key_less(input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b, input logic signed_order);
		logic [KEY_W-1:0] fa;
		logic [KEY_W-1:0] fb;
		fa = a ^ {signed_order, {(KEY_W-1){1'b0}}};
		fb = b ^ {signed_order, {(KEY_W-1){1'b0}}};
		return fa < fb;
	endfunction

endpackage

FILE: rtl/bmhq_ram.sv
// Generic memory with one write port and two registered read ports.
module bmhq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: rtl/bmhq_ctrl.sv
// Sequencer that runs the sift-up and sift-down walks over the heap memory.
module bmhq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  bmhq_pkg::item_t           item,
	output logic                      ready,
	input  logic                      key_order,
	output bmhq_pkg::mem_req_t        mem_req,
	input  logic [bmhq_pkg::KEY_W-1:0] rdata_a,
	input  logic [bmhq_pkg::KEY_W-1:0] rdata_b,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bmhq_pkg::result_t         result
);
	import bmhq_pkg::*;

	localparam int CW = ADDR_W + 2;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] pos_q;
	logic [KEY_W-1:0]  val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [KEY_W-1:0]  top_q;
	status_t           status_q;
	logic [KEY_W-1:0]  popped_q;
	logic              pvalid_q;

	logic [ADDR_W-1:0] pos_m1;
	logic [ADDR_W-1:0] parent;
	logic [CW-1:0]     left_idx;
	logic [CW-1:0]     right_idx;
	logic [CW-1:0]     cnt_ext;
	logic              has_left;
	logic              has_right;
	logic              pick_right;
	logic [KEY_W-1:0]  child_key;
	logic [ADDR_W-1:0] child_pos;
	logic              up_move;
	logic              dn_move;

	assign pos_m1     = pos_q - ADDR_W'(1);
	assign parent     = {1'b0, pos_m1[ADDR_W-1:1]};
	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = left_idx + CW'(1);
	assign cnt_ext    = CW'(cnt_q);
	assign has_left   = left_idx < cnt_ext;
	assign has_right  = right_idx < cnt_ext;
	// On equal children the left one wins.
	assign pick_right = has_right && key_less(rdata_b, rdata_a, key_order);
	assign child_key  = pick_right ? rdata_b : rdata_a;
	assign child_pos  = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
	assign up_move    = key_less(val_q, rdata_a, key_order);
	assign dn_move    = key_less(child_key, val_q, key_order);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.command == CMD_PUSH) begin
						if (cnt_q == CAP_CNT) begin
							state_d = ST_DONE;
						end else if (cnt_q == '0) begin
							state_d = ST_FIN;
						end else begin
							state_d = ST_UP_RD;
						end
					end else begin
						if (cnt_q == CNT_W'(1) || cnt_q == '0) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_POP_RD;
						end
					end
				end
			end
			ST_UP_RD:  state_d = ST_UP_CMP;
			ST_UP_CMP: begin
				if (up_move && parent != '0) begin
					state_d = ST_UP_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_POP_RD: state_d = ST_POP_LD;
			ST_POP_LD: state_d = ST_DN_RD;
			ST_DN_RD:  state_d = has_left ? ST_DN_CMP : ST_FIN;
			ST_DN_CMP: state_d = dn_move ? ST_DN_RD : ST_FIN;
			ST_FIN:    state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// The walk alternates read and compare states, so a read never meets a
	// write to the same entry that is still in flight.
	always_comb begin
		ready           = 1'b0;
		res_valid       = 1'b0;
		mem_req.we      = 1'b0;
		mem_req.waddr   = pos_q;
		mem_req.wdata   = val_q;
		mem_req.raddr_a = left_idx[ADDR_W-1:0];
		mem_req.raddr_b = right_idx[ADDR_W-1:0];
		case (state_q)
			ST_IDLE:   ready = 1'b1;
			ST_UP_RD:  mem_req.raddr_a = parent;
			ST_UP_CMP: begin
				if (up_move) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = rdata_a;
				end
			end
			ST_POP_RD: mem_req.raddr_a = cnt_q[ADDR_W-1:0];
			ST_DN_CMP: begin
				if (dn_move) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = child_key;
				end
			end
			ST_FIN:    mem_req.we = 1'b1;
			ST_DONE:   res_valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				if (item.command == CMD_PUSH && cnt_q != CAP_CNT) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (item.command == CMD_POP && cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.we && mem_req.waddr == '0) begin
			top_q <= mem_req.wdata;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					status_q <= STAT_OK;
					popped_q <= '0;
					pvalid_q <= 1'b0;
					pos_q    <= cnt_q[ADDR_W-1:0];
					val_q    <= item.key;
					if (item.command == CMD_PUSH) begin
						if (cnt_q == CAP_CNT) begin
							status_q <= STAT_FULL;
						end
					end else if (cnt_q == '0) begin
						status_q <= STAT_EMPTY;
					end else begin
						popped_q <= top_q;
						pvalid_q <= 1'b1;
					end
				end
			end
			ST_UP_CMP: begin
				if (up_move) begin
					pos_q <= parent;
				end
			end
			ST_POP_LD: begin
				val_q <= rdata_a;
				pos_q <= '0;
			end
			ST_DN_CMP: begin
				if (dn_move) begin
					pos_q <= child_pos;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.status       = status_q;
		result.popped_key   = popped_q;
		result.popped_valid = pvalid_q;
		result.entry_total  = cnt_q;
		result.top_valid    = cnt_q != '0;
		result.top_key      = (cnt_q != '0) ? top_q : '0;
	end

endmodule

FILE: rtl/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    tdata key, tuser command
//  m_*      out  m_tvalid / m_tready    tdata result fields, tuser status
//  cfg_*    in   cfg_valid / cfg_ready  cfg_data key_order
//
// One item at a time: a push reads and compares once per parent compared; a pop loads the last
// entry into the root, then reads and compares once per level compared and reads once more when it
// ends at a leaf. A full push or a pop with at most one entry goes straight to the result.
// Reset clears the entry count, the key order and the output valid flag; the memory is not cleared.
// A stalled result waits in the output register while the next item is already accepted.
module binary_min_heap_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // [31:0] key
	input  logic [0:0]                        s_tuser,  // [0] command
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] popped_key, [32] popped_valid, [39:33] entry_total,
	// [71:40] top_key, [72] top_valid, rest zero
	output logic [bmhq_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [1:0]                        m_tuser,  // [1:0] status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data
);
	import bmhq_pkg::*;

	logic      key_order_q;
	item_t     item;
	logic      ready;
	mem_req_t  mem_req;
	logic [KEY_W-1:0] rdata_a;
	logic [KEY_W-1:0] rdata_b;
	logic      res_valid;
	logic      res_ready;
	result_t   result;
	logic      out_valid_q;
	result_t   out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_order_q <= 1'b0;
		end else if (cfg_valid) begin
			key_order_q <= cfg_data;
		end
	end

	assign item.command = cmd_t'(s_tuser[0]);
	assign item.key     = s_tdata[KEY_W-1:0];
	assign s_tready     = ready;

	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid),
		.item      (item),
		.ready     (ready),
		.key_order (key_order_q),
		.mem_req   (mem_req),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result    (result)
	);

	bmhq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_W)
	) u_ram (
		.clk     (clk),
		.we      (mem_req.we),
		.waddr   (mem_req.waddr),
		.wdata   (mem_req.wdata),
		.raddr_a (mem_req.raddr_a),
		.raddr_b (mem_req.raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_q.top_valid, out_q.top_key,
		out_q.entry_total, out_q.popped_valid, out_q.popped_key};

endmodule
